### rtl/gravity_vector_smoother_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the gravity vector smoother.
// Same-cycle and next-cycle implication checks, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef GRAVITY_VECTOR_SMOOTHER_UNIT_ASSERT_SVH
`define GRAVITY_VECTOR_SMOOTHER_UNIT_ASSERT_SVH

// cons must hold in the same cycle as ante
`define GVS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// cons must hold in the cycle after ante
`define GVS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/gvs_pkg.sv
// ---------------------------------------------------------------------------
// gvs_pkg
// Types and constants shared by the gravity vector smoother modules.
// ---------------------------------------------------------------------------
package gvs_pkg;

   localparam int GVS_SAMPLE_W   = 16;
   localparam int GVS_ALPHA_W    = 9;
   localparam int GVS_LIMIT_W    = 15;
   localparam int GVS_CSR_IDX_W  = 3;
   localparam int GVS_CSR_DATA_W = 15;

   // 1/9.80665 in Q0.16
   localparam logic signed [15:0] GVS_INV_G = 16'sd6683;

   localparam logic [GVS_ALPHA_W-1:0] GVS_ALPHA_ONE = 9'd256;

   // register indexes
   localparam logic [GVS_CSR_IDX_W-1:0] GVS_CSR_ALPHA     = 3'd0;
   localparam logic [GVS_CSR_IDX_W-1:0] GVS_CSR_CLAMP     = 3'd1;
   localparam logic [GVS_CSR_IDX_W-1:0] GVS_CSR_THRESHOLD = 3'd2;
   localparam logic [GVS_CSR_IDX_W-1:0] GVS_CSR_SWAP_XY   = 3'd3;
   localparam logic [GVS_CSR_IDX_W-1:0] GVS_CSR_NEGATE_X  = 3'd4;
   localparam logic [GVS_CSR_IDX_W-1:0] GVS_CSR_NEGATE_Y  = 3'd5;

   // register reset values
   localparam logic [GVS_ALPHA_W-1:0] GVS_RST_ALPHA     = 9'd102;
   localparam logic [GVS_LIMIT_W-1:0] GVS_RST_CLAMP     = 15'd384;
   localparam logic [GVS_LIMIT_W-1:0] GVS_RST_THRESHOLD = 15'd1280;

   // mid queue
   localparam int GVS_QDEPTH = 2;
   localparam int GVS_QPTR_W = $clog2(GVS_QDEPTH);
   localparam int GVS_QCNT_W = $clog2(GVS_QDEPTH + 1);

   typedef logic signed [GVS_SAMPLE_W-1:0] gvs_sample_type;

   typedef struct packed {
      gvs_sample_type accel_x;
      gvs_sample_type accel_y;
      gvs_sample_type accel_z;
   } gvs_req_type;

   typedef struct packed {
      gvs_sample_type grav_x;
      gvs_sample_type grav_y;
      gvs_sample_type grav_z;
   } gvs_rsp_type;

   // clamped gravity vector handed from front to back
   typedef struct packed {
      gvs_sample_type x;
      gvs_sample_type y;
      gvs_sample_type z;
   } gvs_vec_type;

   typedef struct packed {
      logic [GVS_ALPHA_W-1:0] alpha;
      logic [GVS_LIMIT_W-1:0] clamp_limit;
      logic [GVS_LIMIT_W-1:0] scale_threshold;
      logic                   swap_xy;
      logic                   negate_x;
      logic                   negate_y;
   } gvs_cfg_type;

endpackage

### rtl/gvs_front.sv
// ---------------------------------------------------------------------------
// gvs_front
// Takes samples, detects m/s^2 units, rescales, maps axes and clamps.
// ---------------------------------------------------------------------------
module gvs_front import gvs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  gvs_cfg_type cfg,
   input  logic        req_push,
   output logic        req_full,
   input  gvs_req_type req_data,
   output logic        q_push,
   output gvs_vec_type q_data,
   input  logic        q_full
);

   function automatic gvs_sample_type neg_sat(input gvs_sample_type v);
      gvs_sample_type r;
      if (v == {1'b1, {(GVS_SAMPLE_W-1){1'b0}}}) begin
         r = {1'b0, {(GVS_SAMPLE_W-1){1'b1}}};
      end else begin
         r = -v;
      end
      return r;
   endfunction

   function automatic gvs_sample_type clamp_axis(input gvs_sample_type v,
                                                 input gvs_sample_type lim);
      gvs_sample_type r;
      if (v < -lim) begin
         r = -lim;
      end else if (v > lim) begin
         r = lim;
      end else begin
         r = v;
      end
      return r;
   endfunction

   gvs_sample_type in_ax [3];
   gvs_sample_type raw_ff [3];
   gvs_sample_type scl_ff [3];
   gvs_sample_type scl_in [3];
   logic [30:0]    sq_ff [3];
   logic [30:0]    sq_in [3];
   logic [29:0]    thr2_ff;
   logic [29:0]    thr2_in;
   logic           a_valid_ff;
   logic           a_valid_in;
   logic           accept;

   logic [31:0]    mag2;
   logic           in_mps2;
   gvs_sample_type sel [3];
   gvs_sample_type gx;
   gvs_sample_type gy;
   gvs_sample_type lim;

   assign in_ax[0] = req_data.accel_x;
   assign in_ax[1] = req_data.accel_y;
   assign in_ax[2] = req_data.accel_z;

   // stage A: squares and rescaled copies
   always_comb begin
      logic signed [16:0] ext;
      logic [16:0]        mag;
      logic [33:0]        sqw;
      logic signed [31:0] prod;
      for (int i = 0; i < 3; i++) begin
         ext       = 17'(in_ax[i]);
         mag       = ext[16] ? 17'(-ext) : 17'(ext);
         sqw       = 34'(mag) * 34'(mag);
         sq_in[i]  = sqw[30:0];
         prod      = 32'(in_ax[i]) * 32'(GVS_INV_G);
         scl_in[i] = prod[31:16];
      end
   end

   assign thr2_in = 30'(cfg.scale_threshold) * 30'(cfg.scale_threshold);

   assign req_full   = a_valid_ff & q_full;
   assign accept     = req_push & ~req_full;
   assign q_push     = a_valid_ff & ~q_full;
   assign a_valid_in = accept | (a_valid_ff & ~q_push);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         raw_ff  <= in_ax;
         scl_ff  <= scl_in;
         sq_ff   <= sq_in;
         thr2_ff <= thr2_in;
      end
   end

   // stage B: strict magnitude compare, select, map, clamp
   assign mag2    = 32'(sq_ff[0]) + 32'(sq_ff[1]) + 32'(sq_ff[2]);
   assign in_mps2 = mag2 > 32'(thr2_ff);
   assign lim     = {1'b0, cfg.clamp_limit};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sel[i] = in_mps2 ? scl_ff[i] : raw_ff[i];
      end
      gx = cfg.swap_xy ? sel[1] : sel[0];
      gy = cfg.swap_xy ? sel[0] : sel[1];
      if (cfg.negate_x) begin
         gx = neg_sat(gx);
      end
      if (cfg.negate_y) begin
         gy = neg_sat(gy);
      end
      q_data.x = clamp_axis(gx, lim);
      q_data.y = clamp_axis(gy, lim);
      q_data.z = clamp_axis(sel[2], lim);
   end

endmodule

### rtl/gvs_fifo.sv
// ---------------------------------------------------------------------------
// gvs_fifo
// Short queue between front and back; head word shown while not empty.
// ---------------------------------------------------------------------------
module gvs_fifo import gvs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  gvs_vec_type wdata,
   output logic        full,
   input  logic        pop,
   output logic        empty,
   output gvs_vec_type rdata
);

   gvs_vec_type           slot_ff [GVS_QDEPTH];
   logic [GVS_QPTR_W-1:0] wr_ptr_ff;
   logic [GVS_QPTR_W-1:0] wr_ptr_in;
   logic [GVS_QPTR_W-1:0] rd_ptr_ff;
   logic [GVS_QPTR_W-1:0] rd_ptr_in;
   logic [GVS_QCNT_W-1:0] count_ff;
   logic [GVS_QCNT_W-1:0] count_in;
   logic                  do_push;
   logic                  do_pop;

   localparam logic [GVS_QPTR_W-1:0] PTR_LAST = GVS_QPTR_W'(GVS_QDEPTH - 1);
   localparam logic [GVS_QCNT_W-1:0] CNT_FULL = GVS_QCNT_W'(GVS_QDEPTH);

   assign full    = count_ff == CNT_FULL;
   assign empty   = count_ff == '0;
   assign rdata   = slot_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

### rtl/gvs_back.sv
// ---------------------------------------------------------------------------
// gvs_back
// One-pole low-pass per axis: multiply, then accumulate into filter state.
// ---------------------------------------------------------------------------
`include "gravity_vector_smoother_unit_assert.svh"

module gvs_back import gvs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  gvs_cfg_type cfg,
   input  logic        q_empty,
   input  gvs_vec_type q_head,
   output logic        q_pop,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output gvs_rsp_type rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_UPDATE = 2'b10
   } gvs_back_state_type;

   gvs_back_state_type     state_ff;
   gvs_back_state_type     state_in;
   logic signed [26:0]     prod_ff [3];
   logic signed [26:0]     prod_in [3];
   gvs_sample_type         filt_ff [3];
   gvs_sample_type         filt_in [3];
   gvs_sample_type         g [3];
   gvs_rsp_type            out_ff;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   logic [GVS_ALPHA_W-1:0] alpha_sat;
   logic                   upd_fire;

   assign g[0] = q_head.x;
   assign g[1] = q_head.y;
   assign g[2] = q_head.z;

   assign alpha_sat = (cfg.alpha > GVS_ALPHA_ONE) ? GVS_ALPHA_ONE : cfg.alpha;
   assign q_pop     = (state_ff == ST_IDLE) & ~q_empty;
   assign upd_fire  = (state_ff == ST_UPDATE) & (~out_valid_ff | rsp_pop);

   // alpha * (g - f)
   always_comb begin
      logic signed [16:0] diff;
      for (int i = 0; i < 3; i++) begin
         diff       = 17'(g[i]) - 17'(filt_ff[i]);
         prod_in[i] = 27'(diff) * 27'(signed'({1'b0, alpha_sat}));
      end
   end

   // f += prod >>> 8 (floor)
   always_comb begin
      logic signed [18:0] step;
      logic signed [18:0] acc;
      for (int i = 0; i < 3; i++) begin
         step       = prod_ff[i][26:8];
         acc        = 19'(filt_ff[i]) + step;
         filt_in[i] = acc[15:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (upd_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign out_valid_in = upd_fire | (out_valid_ff & ~rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            filt_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         if (upd_fire) begin
            filt_ff <= filt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         prod_ff <= prod_in;
      end
      if (upd_fire) begin
         out_ff.grav_x <= filt_in[0];
         out_ff.grav_y <= filt_in[1];
         out_ff.grav_z <= filt_in[2];
      end
   end

   assign rsp_empty = ~out_valid_ff;
   assign rsp_data  = out_ff;

   `GVS_ASSERT_NEXT(a_pop_to_update, clock, reset, q_pop, state_ff == ST_UPDATE, "pop did not start update")
   `GVS_ASSERT_NEXT(a_update_shows, clock, reset, upd_fire, !rsp_empty, "update left no word")
   `GVS_ASSERT_NEXT(a_filt_hold, clock, reset, !upd_fire, $stable(filt_ff[0]) && $stable(filt_ff[1]) && $stable(filt_ff[2]), "filter moved without update")

endmodule

### rtl/gravity_vector_smoother_unit.sv
// ---------------------------------------------------------------------------
// gravity_vector_smoother_unit
// Accelerometer sample in, low-pass filtered gravity vector out.
// ---------------------------------------------------------------------------
//  channel | ports                              | word
//  --------+------------------------------------+-----------------------------
//  req     | req_push, req_full, req_data       | accel_x/y/z, Q8.8 signed
//  rsp     | rsp_empty, rsp_pop, rsp_data       | grav_x/y/z, Q8.8 g signed
//  csr     | csr_write, csr_index, csr_wdata    | 6 registers, write only
//
//  The back end takes a new word from the queue only after its filter loop
//  is done with the last (multiply, then accumulate into filter state).
//  When nothing stalls, rsp_empty falls once a word has passed the front
//  register, the queue, the product register and the result register.
//  Front keeps taking words while the back end or rsp stalls, until the
//  2-entry queue and the front register fill; req_full then rises.
//  Synchronous reset restores register defaults and zeros filter state.
// ---------------------------------------------------------------------------
module gravity_vector_smoother_unit import gvs_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   // input words
   input  logic                      req_push,
   output logic                      req_full,
   input  gvs_req_type               req_data,
   // result words
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output gvs_rsp_type               rsp_data,
   // register writes
   input  logic                      csr_write,
   input  logic [GVS_CSR_IDX_W-1:0]  csr_index,
   input  logic [GVS_CSR_DATA_W-1:0] csr_wdata
);

   gvs_cfg_type cfg_ff;
   gvs_cfg_type cfg_in;

   logic        q_push;
   logic        q_full;
   logic        q_pop;
   logic        q_empty;
   gvs_vec_type q_wdata;
   gvs_vec_type q_head;

   // register file: unused indexes drop the write, wide data is truncated
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            GVS_CSR_ALPHA:     cfg_in.alpha           = csr_wdata[GVS_ALPHA_W-1:0];
            GVS_CSR_CLAMP:     cfg_in.clamp_limit     = csr_wdata[GVS_LIMIT_W-1:0];
            GVS_CSR_THRESHOLD: cfg_in.scale_threshold = csr_wdata[GVS_LIMIT_W-1:0];
            GVS_CSR_SWAP_XY:   cfg_in.swap_xy         = csr_wdata[0];
            GVS_CSR_NEGATE_X:  cfg_in.negate_x        = csr_wdata[0];
            GVS_CSR_NEGATE_Y:  cfg_in.negate_y        = csr_wdata[0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha           <= GVS_RST_ALPHA;
         cfg_ff.clamp_limit     <= GVS_RST_CLAMP;
         cfg_ff.scale_threshold <= GVS_RST_THRESHOLD;
         cfg_ff.swap_xy         <= 1'b0;
         cfg_ff.negate_x        <= 1'b1;
         cfg_ff.negate_y        <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: unit detect, rescale, axis map, clamp
   gvs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_push   (q_push),
      .q_data   (q_wdata),
      .q_full   (q_full)
   );

   // decoupling queue
   gvs_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .empty (q_empty),
      .rdata (q_head)
   );

   // back: per-axis low-pass and result register
   gvs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
